/* hdl/random_string_scorer_macros.svh */
// Assertion macros for the random string scorer.
// Used by the top level; no other dependencies.
`ifndef RANDOM_STRING_SCORER_MACROS_SVH
`define RANDOM_STRING_SCORER_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define RSS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define RSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rss_pkg.sv */
// Package for the random string scorer: widths, limits, codes and the trigram ROM.
// Standalone; used by random_string_scorer.
package rss_pkg;

   localparam int unsigned RUN_W     = 8;
   localparam int unsigned HITS_W    = 10;
   localparam int unsigned SCORE_W   = 10;
   localparam int unsigned TOTAL_W   = 12;
   localparam int unsigned THRESH_W  = 7;
   localparam int unsigned ACTION_W  = 2;
   localparam int unsigned VERDICT_W = 3;
   localparam int unsigned LETTERS   = 26;

   localparam logic [RUN_W-1:0]   MAX_RUN    = 8'd255;
   localparam logic [RUN_W-1:0]   DIGIT_MIN  = 8'd5;
   localparam logic [RUN_W-1:0]   LETTER_MIN = 8'd4;
   localparam logic [HITS_W-1:0]  HITS_MAX   = 10'd1023;
   localparam logic [SCORE_W-1:0] SCORE_MAX  = 10'd1023;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX  = 12'd4095;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd10;
   localparam logic [ACTION_W-1:0] ACTION_RESET = 2'd3;

   typedef enum logic [0:0] {
      CSR_THRESHOLD  = 1'b0,
      CSR_BAN_ACTION = 1'b1
   } csr_index_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_PASS      = 3'd0,
      VERDICT_KILL      = 3'd1,
      VERDICT_ZLINE     = 3'd2,
      VERDICT_GLINE     = 3'd3,
      VERDICT_NO_ACTION = 3'd4
   } verdict_type;

   function automatic logic is_lower(input logic [7:0] c);
      return (c >= "a") && (c <= "z");
   endfunction

   function automatic logic is_vowel(input logic [7:0] c);
      return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u");
   endfunction

   function automatic logic is_consonant(input logic [7:0] c);
      return is_lower(c) && !is_vowel(c) && (c != "y");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // Turn a string of lowercase letters into a letter bit mask, bit 0 = 'a'.
   function automatic logic [LETTERS-1:0] letter_set(input logic [8*LETTERS-1:0] s);
      logic [LETTERS-1:0] m;
      logic [7:0]         ch;
      logic [7:0]         off;
      m = '0;
      for (int i = 0; i < LETTERS; i++) begin
         ch = s[8*i +: 8];
         off = ch - 8'h61;
         if (is_lower(ch)) m[off[4:0]] = 1'b1;
      end
      return m;
   endfunction

   // Forbidden third letters following the pair a, b.
   function automatic logic [LETTERS-1:0] trigram_set(input logic [7:0] a,
                                                       input logic [7:0] b);
      logic [LETTERS-1:0] r;
      case ({a, b})
         "aj": r = letter_set("fqtvxz");
         "aq": r = letter_set("deghjkmnprtxyz");
         "av": r = letter_set("bfhjqwxz");
         "az": r = letter_set("jwx");
         "bd": r = letter_set("bghjkmpqvxz");
         "bf": r = letter_set("bcfgjknpqvwxyz");
         "bg": r = letter_set("bdfghjkmnqstvxz");
         "bh": r = letter_set("bfhjkmnqvwxz");
         "bj": r = letter_set("bcdfghjklmpqtvwxyz");
         "bk": r = letter_set("dfjkmqrvwxyz");
         "bl": r = letter_set("bgpqwxz");
         "bm": r = letter_set("bcdflmnqz");
         "bn": r = letter_set("bghjlmnpqtvwx");
         "bp": r = letter_set("bfgjknqvxz");
         "bq": r = letter_set("bcdefghijklmnopqrstvwxyz");
         "bt": r = letter_set("dgjkpqtxz");
         "bv": r = letter_set("bfghjklnpqsuvwxz");
         "bw": r = letter_set("bdfjknpqsuwxyz");
         "bx": r = letter_set("abcdfghijklmnopqtuvwxyz");
         "bz": r = letter_set("bcdfgjklmnpqrstvwxz");
         "cb": r = letter_set("bfghjkpqyz");
         "cc": r = letter_set("gjqxz");
         "cd": r = letter_set("hjkqvwxz");
         "cf": r = letter_set("gjknqvwyz");
         "cg": r = letter_set("bdfgjkpqvz");
         "cl": r = letter_set("fghjmpqxz");
         "cm": r = letter_set("bjkqv");
         "cn": r = letter_set("bghjkpqwxz");
         "cp": r = letter_set("gjkvxyz");
         "cq": r = letter_set("abcdefghijklmnopqsvwxyz");
         "cr": r = letter_set("gjqx");
         "cs": r = letter_set("gjxz");
         "cv": r = letter_set("bdfghjklmnquvwxyz");
         "cx": r = letter_set("abdefghjklmnpqrstuvwxyz");
         "cy": r = letter_set("jqy");
         "cz": r = letter_set("bcdfghjlpqrtvwxz");
         "db": r = letter_set("bdgjnpqtxz");
         "dc": r = letter_set("gjqxz");
         "dd": r = letter_set("gqz");
         "df": r = letter_set("bghjknpqvxyz");
         "dg": r = letter_set("bfgjqvxz");
         "dh": r = letter_set("bfkmnqwxz");
         "dj": r = letter_set("bdfghjklnpqrwxz");
         "dk": r = letter_set("cdhjkpqrtuvwxz");
         "dl": r = letter_set("bfhjknqwxz");
         "dm": r = letter_set("bfjnqw");
         "dn": r = letter_set("fgjkmnpqvwz");
         "dp": r = letter_set("bgjkqvxz");
         "dq": r = letter_set("abcefghijkmnopqtvwxyz");
         "dr": r = letter_set("bfkqtvx");
         "dt": r = letter_set("qtxz");
         "dv": r = letter_set("bfghjknqruvwyz");
         "dw": r = letter_set("cdfjkmnpqsvwxz");
         "dx": r = letter_set("abcdeghjklmnopqrsuvwxyz");
         "dy": r = letter_set("jyz");
         "dz": r = letter_set("bcdfgjlnpqrstvxz");
         "eb": r = letter_set("jqx");
         "eg": r = letter_set("cjvxz");
         "eh": r = letter_set("hxz");
         "ej": r = letter_set("fghjpqtwxyz");
         "ek": r = letter_set("jqxz");
         "ep": r = letter_set("jvx");
         "eq": r = letter_set("bcghijkmotvxyz");
         "ev": r = letter_set("bfpq");
         "fc": r = letter_set("bdjkmnqvxz");
         "fd": r = letter_set("bgjklqsvyz");
         "fg": r = letter_set("fgjkmpqtvwxyz");
         "fh": r = letter_set("bcfghjkpqvwxz");
         "fj": r = letter_set("bcdfghijklmnpqrstvwxyz");
         "fk": r = letter_set("bcdfghjkmpqrstvwxz");
         "fl": r = letter_set("fjkpqxz");
         "fm": r = letter_set("dfhjlmvwxyz");
         "fn": r = letter_set("bdfghjklnqrstvwxz");
         "fp": r = letter_set("bfjknqtvwxz");
         "fq": r = letter_set("abcefghijklmnopqrstvwxyz");
         "fr": r = letter_set("nqxz");
         "fs": r = letter_set("gjxz");
         "ft": r = letter_set("jqx");
         "fv": r = letter_set("bcdfhjklmnpqtuvwxyz");
         "fw": r = letter_set("bcfgjklmpqstuvwxyz");
         "fx": r = letter_set("bcdfghjklmnpqrstvwxyz");
         "fy": r = letter_set("ghjpquvxy");
         "fz": r = letter_set("abcdfghjklmnpqrtuvwxyz");
         "gb": r = letter_set("bcdknpqvwx");
         "gc": r = letter_set("gjknpqwxz");
         "gd": r = letter_set("cdfghjklmqtvwxz");
         "gf": r = letter_set("bfghjkmnpqsvwxyz");
         "gg": r = letter_set("jkqvxz");
         "gj": r = letter_set("bcdfghjklmnpqrstvwxyz");
         "gk": r = letter_set("bcdfgjkmpqtvwxyz");
         "gl": r = letter_set("fgjklnpqwxz");
         "gm": r = letter_set("dfjkmnqvxz");
         "gn": r = letter_set("jkqvxz");
         "gp": r = letter_set("bjknpqtwxyz");
         "gq": r = letter_set("abcdefghjklmnopqrsvwxyz");
         "gr": r = letter_set("jkqt");
         "gt": r = letter_set("fjknqvx");
         "gu": r = letter_set("qwx");
         "gv": r = letter_set("bcdfghjklmpqstvwxyz");
         "gw": r = letter_set("bcdfgjknpqtvwxz");
         "gx": r = letter_set("abcdefghjklmnopqrstvwxyz");
         "gy": r = letter_set("jkqxy");
         "gz": r = letter_set("bcdfgjklmnopqrstvxyz");
         "hb": r = letter_set("bcdfghjkqstvwxz");
         "hc": r = letter_set("cjknqvwxz");
         "hd": r = letter_set("fgjnpvz");
         "hf": r = letter_set("bfghjkmnpqtvwxyz");
         "hg": r = letter_set("bcdfgjknpqsxyz");
         "hh": r = letter_set("bcgklmpqrtvwxz");
         "hj": r = letter_set("bcdfgjkmpqtvwxyz");
         "hk": r = letter_set("bcdgkmpqrstvwxz");
         "hl": r = letter_set("jxz");
         "hm": r = letter_set("dhjqrvwxz");
         "hn": r = letter_set("jrxz");
         "hp": r = letter_set("bjkmqvwxyz");
         "hq": r = letter_set("abcdefghijklmnopqrstvwyz");
         "hr": r = letter_set("cjqx");
         "hs": r = letter_set("jqxz");
         "hv": r = letter_set("bcdfgjklmnpqstuvwxz");
         "hw": r = letter_set("bcfgjklnpqsvwxz");
         "hx": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "hz": r = letter_set("bcdfghjklmnpqrstuvwxz");
         "ib": r = letter_set("jqx");
         "if": r = letter_set("jqvwz");
         "ih": r = letter_set("bgjqx");
         "ii": r = letter_set("bjqxy");
         "ij": r = letter_set("cfgqxy");
         "ik": r = letter_set("bcfqx");
         "iq": r = letter_set("cdefgjkmnopqtvxyz");
         "iu": r = letter_set("hiwxy");
         "iv": r = letter_set("cfgmqx");
         "iw": r = letter_set("dgjkmnpqtvxz");
         "ix": r = letter_set("jkqrxz");
         "iy": r = letter_set("bcdfghjklpqtvwx");
         "jb": r = letter_set("bcdghjklmnopqrtuvwxyz");
         "jc": r = letter_set("cfgjkmnopqvwxy");
         "jd": r = letter_set("cdfghjlmnpqrtvwx");
         "jf": r = letter_set("abcdfghjlnopqrtuvwxyz");
         "jg": r = letter_set("bcdfghijklmnopqstuvwxyz");
         "jh": r = letter_set("bcdfghjklmnpqrxyz");
         "jj": r = letter_set("bcdfghjklmnopqrstuvwxyz");
         "jk": r = letter_set("bcdfghjknqrtwxyz");
         "jl": r = letter_set("bcfghjmnpqrstuvwxyz");
         "jm": r = letter_set("bcdfghiklmnqrtuvwyz");
         "jn": r = letter_set("bcfjlmnpqsuvwxz");
         "jp": r = letter_set("bcdfhijkmpqstvwxyz");
         "jq": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "jr": r = letter_set("bdfhjklpqrstuvwxyz");
         "js": r = letter_set("bfgjmoqvxyz");
         "jt": r = letter_set("bcdfghjlnpqrtvwxz");
         "jv": r = letter_set("abcdfghijklpqrstvwxyz");
         "jw": r = letter_set("bcdefghijklmpqrstuwxyz");
         "jx": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "jy": r = letter_set("bcdefghjkpqtuvwxyz");
         "jz": r = letter_set("bcdfghijklmnopqrstuvwxyz");
         "kb": r = letter_set("bcdfghjkmqvwxz");
         "kc": r = letter_set("cdfgjknpqtwxz");
         "kd": r = letter_set("bfghjklmnpqsvwxyz");
         "kf": r = letter_set("bdfghjkmnpqsvwxyz");
         "kg": r = letter_set("cghjkmnqtvwxyz");
         "kh": r = letter_set("cfghjkqx");
         "kj": r = letter_set("bcdfghjkmnpqrstwxyz");
         "kk": r = letter_set("bcdfgjmpqswxz");
         "kl": r = letter_set("cfghlmqstwxz");
         "km": r = letter_set("bdfghjknqrstwxyz");
         "kn": r = letter_set("bcdfhjklmnqsvwxz");
         "kp": r = letter_set("bdfgjkmpqvxyz");
         "kq": r = letter_set("abdefghijklmnopqrstvwxyz");
         "kr": r = letter_set("bcdfghjmqrvwx");
         "ks": r = letter_set("jqx");
         "kt": r = letter_set("cdfjklqvx");
         "ku": r = letter_set("qux");
         "kv": r = letter_set("bcfghjklnpqrstvxyz");
         "kw": r = letter_set("bcdfgjklmnpqsvwxz");
         "kx": r = letter_set("abcdefghjklmnopqrstuvwxyz");
         "ky": r = letter_set("vxy");
         "kz": r = letter_set("bcdefghjklmnpqrstuvwxyz");
         "lb": r = letter_set("cdgkqtvxz");
         "lc": r = letter_set("bqx");
         "lg": r = letter_set("cdfgpqvxz");
         "lh": r = letter_set("cfghkmnpqrtvx");
         "lk": r = letter_set("qxz");
         "ln": r = letter_set("cfjqxz");
         "lp": r = letter_set("jkqxz");
         "lq": r = letter_set("bcdefhijklmopqrstvwxyz");
         "lr": r = letter_set("dfgjklmpqrtvwx");
         "lv": r = letter_set("bcfhjklmpwxz");
         "lw": r = letter_set("bcdfgjknqxz");
         "lx": r = letter_set("bcdfghjklmnpqrtuwz");
         "lz": r = letter_set("cdjptvxz");
         "mb": r = letter_set("qxz");
         "md": r = letter_set("hjkpvz");
         "mf": r = letter_set("fkpqvwxz");
         "mg": r = letter_set("cfgjnpqsvwxz");
         "mh": r = letter_set("bchjkmnqvx");
         "mj": r = letter_set("bcdfghjknpqrstvwxyz");
         "mk": r = letter_set("bcfgklmnpqrvwxz");
         "ml": r = letter_set("jkqz");
         "mm": r = letter_set("qvz");
         "mn": r = letter_set("fhjkqxz");
         "mq": r = letter_set("bdefhjklmnopqtwxyz");
         "mr": r = letter_set("jklqvwz");
         "mt": r = letter_set("jkq");
         "mv": r = letter_set("bcfghjklmnqtvwxz");
         "mw": r = letter_set("bcdfgjklnpqsuvwxyz");
         "mx": r = letter_set("abcefghijklmnopqrstvwxyz");
         "mz": r = letter_set("bcdfghjkmnpqrstvwxz");
         "nb": r = letter_set("hkmnqxz");
         "nf": r = letter_set("bghqvxz");
         "nh": r = letter_set("fhjkmqtvxz");
         "nk": r = letter_set("qxz");
         "nl": r = letter_set("bghjknqvwxz");
         "nm": r = letter_set("dfghjkqtvwxz");
         "np": r = letter_set("bdjmqwxz");
         "nq": r = letter_set("abcdfghjklmnopqrtvwxyz");
         "nr": r = letter_set("bfjkqstvx");
         "nv": r = letter_set("bcdfgjkmnqswxz");
         "nw": r = letter_set("dgjpqvxz");
         "nx": r = letter_set("abfghjknopuyz");
         "nz": r = letter_set("cfqrxz");
         "oc": r = letter_set("fjvw");
         "og": r = letter_set("qxz");
         "oh": r = letter_set("fqxz");
         "oj": r = letter_set("bfhjmqrswxyz");
         "ok": r = letter_set("qxz");
         "oq": r = letter_set("bcdefghijklmnopqrstvwxyz");
         "ov": r = letter_set("bfhjqwx");
         "oy": r = letter_set("qxy");
         "oz": r = letter_set("fjpqtvx");
         "pb": r = letter_set("fghjknpqvwz");
         "pc": r = letter_set("gjq");
         "pd": r = letter_set("bgjkvwxz");
         "pf": r = letter_set("hjkmqtvwyz");
         "pg": r = letter_set("bdfghjkmqsvwxyz");
         "ph": r = letter_set("kqvx");
         "pk": r = letter_set("bcdfhjklmpqrvx");
         "pl": r = letter_set("ghkqvwx");
         "pm": r = letter_set("bfhjlmnqvwyz");
         "pn": r = letter_set("fjklmnqrtvwz");
         "pp": r = letter_set("gqwxz");
         "pq": r = letter_set("abcdefghijklmnopqstvwxyz");
         "pr": r = letter_set("hjkqrwx");
         "pt": r = letter_set("jqxz");
         "pv": r = letter_set("bdfghjklquvwxyz");
         "pw": r = letter_set("fjkmnpqsuvwxz");
         "px": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "pz": r = letter_set("bdefghjklmnpqrstuvwxyz");
         "qa": r = letter_set("ceghkopqxy");
         "qb": r = letter_set("bcdfghjklmnqrstuvwxyz");
         "qc": r = letter_set("abcdfghijklmnopqrstuvwxyz");
         "qd": r = letter_set("defghijklmpqrstuvwxyz");
         "qe": r = letter_set("abceghjkmopquwxyz");
         "qf": r = letter_set("abdfghijklmnopqrstuvwxyz");
         "qg": r = letter_set("abcdefghijklmnopqrtuvwxz");
         "qh": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "qi": r = letter_set("efgijkmpwx");
         "qj": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "qk": r = letter_set("abcdfghijklmnopqrsuvwxyz");
         "ql": r = letter_set("abcefghjklmnopqrtuvwxyz");
         "qm": r = letter_set("bdehijklmnoqrtuvxyz");
         "qn": r = letter_set("bcdefghijklmnoqrtuvwxyz");
         "qo": r = letter_set("abcdefgijkloqstuvwxyz");
         "qp": r = letter_set("abcdefghijkmnopqrsuvwxyz");
         "qq": r = letter_set("bcdefghijklmnopstwxyz");
         "qr": r = letter_set("bdefghijklmnoqruvwxyz");
         "qs": r = letter_set("bcdefgijknqruvwxz");
         "qt": r = letter_set("befghjklmnpqtuvwxz");
         "qu": r = letter_set("cfgjkpwz");
         "qv": r = letter_set("abdefghjklmnopqrtuvwxyz");
         "qw": r = letter_set("bcdfghijkmnopqrstuvwxyz");
         "qx": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "qy": r = letter_set("abcdefghjklmnopqrstuvwxyz");
         "qz": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "rb": r = letter_set("fxz");
         "rg": r = letter_set("jvxz");
         "rh": r = letter_set("hjkqrxz");
         "rj": r = letter_set("bdfghjklmpqrstvwxz");
         "rk": r = letter_set("qxz");
         "rl": r = letter_set("jnq");
         "rp": r = letter_set("jxz");
         "rq": r = letter_set("bcdefghijklmnopqrtvwxy");
         "rr": r = letter_set("jpqxz");
         "rv": r = letter_set("bcdfghjmpqrvwxz");
         "rw": r = letter_set("bfgjklqsvxz");
         "rx": r = letter_set("bcdfgjkmnopqrtuvwxz");
         "rz": r = letter_set("djpqvxz");
         "sb": r = letter_set("kpqtvxz");
         "sd": r = letter_set("jqxz");
         "sf": r = letter_set("bghjkpqw");
         "sg": r = letter_set("cgjkqvwxz");
         "sj": r = letter_set("bfghjkmnpqrstvwxz");
         "sk": r = letter_set("qxz");
         "sl": r = letter_set("gjkqwxz");
         "sm": r = letter_set("fkqwxz");
         "sn": r = letter_set("dhjknqvwxz");
         "sq": r = letter_set("bfghjkmopstvwxz");
         "sr": r = letter_set("jklqrwxz");
         "sv": r = letter_set("bfhjklmnqtwxyz");
         "sw": r = letter_set("jkpqvwxz");
         "sx": r = letter_set("bcdefghjklmnopqrtuvwxyz");
         "sy": r = letter_set("qxy");
         "sz": r = letter_set("bdfgjpqsvxz");
         "tb": r = letter_set("cghjkmnpqtvwx");
         "tc": r = letter_set("jnqvx");
         "td": r = letter_set("bfgjkpqtvxz");
         "tf": r = letter_set("ghjkqvwyz");
         "tg": r = letter_set("bdfghjkmpqsx");
         "tj": r = letter_set("bdfhjklmnpqstvwxyz");
         "tk": r = letter_set("bcdfghjklmpqvwxz");
         "tl": r = letter_set("jkqwxz");
         "tm": r = letter_set("bknqtwxz");
         "tn": r = letter_set("fhjkmqvwxz");
         "tp": r = letter_set("bjpqvwxz");
         "tq": r = letter_set("abdefhijklmnopqrstvwxyz");
         "tr": r = letter_set("gjqvx");
         "tv": r = letter_set("bcfghjknpquvwxz");
         "tw": r = letter_set("bcdfjknqvz");
         "tx": r = letter_set("bcdefghjklmnopqrsuvwxz");
         "tz": r = letter_set("jqxz");
         "uc": r = letter_set("fjmvx");
         "uf": r = letter_set("jpqvx");
         "ug": r = letter_set("qvx");
         "uh": r = letter_set("bcgjkpvxz");
         "uj": r = letter_set("wbfghklmqvwx");
         "uk": r = letter_set("fgqxz");
         "uq": r = letter_set("bcdfghijklmnopqrtwxyz");
         "uu": r = letter_set("fijkqvwyz");
         "uv": r = letter_set("bcdfghjkmpqtwxz");
         "uw": r = letter_set("dgjnquvxyz");
         "ux": r = letter_set("jqxz");
         "uy": r = letter_set("jqxyz");
         "uz": r = letter_set("fgkpqrx");
         "vb": r = letter_set("bcdfhijklmpqrtuvxyz");
         "vc": r = letter_set("bgjklnpqtvwxyz");
         "vd": r = letter_set("bdghjklnqvwxyz");
         "vf": r = letter_set("bfghijklmnpqtuvxz");
         "vg": r = letter_set("bcdgjkmnpqtuvwxyz");
         "vh": r = letter_set("bcghijklmnpqrtuvwxyz");
         "vj": r = letter_set("abcdfghijklmnpqrstuvwxyz");
         "vk": r = letter_set("bcdefgjklmnpqruvwxyz");
         "vl": r = letter_set("hjkmpqrvwxz");
         "vm": r = letter_set("bfghjknpquvxyz");
         "vn": r = letter_set("bdhjkmnpqrtuvwxz");
         "vp": r = letter_set("bcdeghjkmopqtuvwyz");
         "vq": r = letter_set("abcdefghijklmnopqrstvwxyz");
         "vr": r = letter_set("fghjknqrtvwxz");
         "vs": r = letter_set("dfgjmqz");
         "vt": r = letter_set("bdfgjklmnqtx");
         "vu": r = letter_set("afhjquwxy");
         "vv": r = letter_set("cdfghjkmnpqrtuwxz");
         "vw": r = letter_set("abcdefghijklmnopqrtuvwxyz");
         "vx": r = letter_set("abcefghjklmnopqrstuvxyz");
         "vy": r = letter_set("oqx");
         "vz": r = letter_set("abcdefgjklmpqrstvwxyz");
         "wb": r = letter_set("bdfghjpqtvxz");
         "wc": r = letter_set("bdfgjkmnqvwx");
         "wd": r = letter_set("dfjpqvxz");
         "wf": r = letter_set("cdghjkmqvwxyz");
         "wg": r = letter_set("bcdfgjknpqtvwxyz");
         "wh": r = letter_set("cdghjklpqvwxz");
         "wj": r = letter_set("bfghijklmnpqrstvwxyz");
         "wk": r = letter_set("cdfgjkpqtuvxz");
         "wl": r = letter_set("jqvxz");
         "wm": r = letter_set("dghjlnqtvwxz");
         "wp": r = letter_set("dfgjkpqtvwxz");
         "wq": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "wr": r = letter_set("cfghjlmpqwx");
         "wt": r = letter_set("bdgjlmnpqtvx");
         "wu": r = letter_set("aikoquvwy");
         "wv": r = letter_set("bcdfghjklmnpqrtuvwxyz");
         "ww": r = letter_set("bcdgkpqstuvxyz");
         "wx": r = letter_set("abcdefghijklmnopqrstuvwxz");
         "wy": r = letter_set("jquwxy");
         "wz": r = letter_set("bcdfghjkmnopqrstuvwxz");
         "xa": r = letter_set("ajoqy");
         "xb": r = letter_set("bcdfghjkmnpqsvwxz");
         "xc": r = letter_set("bcdgjkmnqsvwxz");
         "xd": r = letter_set("bcdfghjklnpqstuvwxyz");
         "xf": r = letter_set("bcdfghjkmnpqtvwxyz");
         "xg": r = letter_set("bcdfghjkmnpqstvwxyz");
         "xh": r = letter_set("cdfghjkmnpqrstvwxz");
         "xi": r = letter_set("jkqy");
         "xj": r = letter_set("abcdefghijklmnopqrstvwxyz");
         "xk": r = letter_set("abcdfghjkmnopqrstuvwxyz");
         "xl": r = letter_set("bcdfghjklmnpqrvwxz");
         "xm": r = letter_set("bcdfghjknpqvwxz");
         "xn": r = letter_set("bcdfghjklmnpqrvwxyz");
         "xp": r = letter_set("bcfjknpqvxz");
         "xq": r = letter_set("abcdefghijklmnopqrstvwxyz");
         "xr": r = letter_set("bcdfghjklnpqrsvwyz");
         "xs": r = letter_set("bdfgjmnqrsvxz");
         "xt": r = letter_set("jkpqvwxz");
         "xu": r = letter_set("fhjkquwx");
         "xv": r = letter_set("bcdefghjklmnpqrsuvwxyz");
         "xw": r = letter_set("bcdfghjklmnpqrtuvwxyz");
         "xx": r = letter_set("bcdefghjkmnpqrstuwyz");
         "xy": r = letter_set("jxy");
         "xz": r = letter_set("abcdefghjklmnpqrstuvwxyz");
         "yb": r = letter_set("cfghjmpqtvwxz");
         "yc": r = letter_set("bdfgjmpqsvwx");
         "yd": r = letter_set("chjkpqvwx");
         "yf": r = letter_set("bcdghjmnpqsvwx");
         "yg": r = letter_set("cfjkpqtxz");
         "yh": r = letter_set("bcdfghjkpqx");
         "yi": r = letter_set("hjqwxy");
         "yj": r = letter_set("bcdfghjklmnpqrstvwxyz");
         "yk": r = letter_set("bcdfgpqvwxz");
         "ym": r = letter_set("dfgjqvxz");
         "yp": r = letter_set("bcdfgjkmqxz");
         "yq": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "yr": r = letter_set("jqx");
         "yt": r = letter_set("bcfgjnpqx");
         "yv": r = letter_set("bcdfghjlmnpqstvwxz");
         "yw": r = letter_set("bfgjklmnpqstuvwxz");
         "yx": r = letter_set("bcdfghjknpqrstuvwxz");
         "yy": r = letter_set("bcdfghjklpqrstvwxz");
         "yz": r = letter_set("bcdfjklmnpqtvwx");
         "zb": r = letter_set("dfgjklmnpqstvwxz");
         "zc": r = letter_set("bcdfgjmnpqstvwxy");
         "zd": r = letter_set("bcdfghjklmnpqstvwxy");
         "zf": r = letter_set("bcdfghijkmnopqrstvwxyz");
         "zg": r = letter_set("bcdfgjkmnpqtvwxyz");
         "zh": r = letter_set("bcfghjlpqstvwxz");
         "zj": r = letter_set("abcdfghjklmnpqrstuvwxyz");
         "zk": r = letter_set("bcdfghjklmpqstvwxz");
         "zl": r = letter_set("bcdfghjlnpqrstvwxz");
         "zm": r = letter_set("bdfghjklmpqstvwxyz");
         "zn": r = letter_set("bcdfghjlmnpqrstuvwxz");
         "zp": r = letter_set("bcdfhjklmnpqstvwxz");
         "zq": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "zr": r = letter_set("bcfghjklmnpqrstvwxyz");
         "zs": r = letter_set("bdfgjmnqrsuwxyz");
         "zt": r = letter_set("bcdfgjkmnpqtuvwxz");
         "zu": r = letter_set("ajqx");
         "zv": r = letter_set("bcdfghjklmnpqrstuvwxyz");
         "zw": r = letter_set("bcdfghjklmnpqrstuvwxyz");
         "zx": r = letter_set("abcdefghijklmnopqrstuvwxyz");
         "zy": r = letter_set("fxy");
         "zz": r = letter_set("cdfhjnpqrvx");
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* hdl/random_string_scorer.sv */
// Top level of the random string scorer: byte stream in, string and record scores out.
// Depends on rss_pkg and random_string_scorer_macros.svh.
//
// The scorer takes one byte per item on the req_ stream and can take a new item in
// every cycle. A zero byte ends a string; req_tlast on that terminator also closes the
// record. Each terminator yields exactly one result item one cycle after it is
// accepted, carrying the string score (longest digit run of 5 or more, longest vowel
// and consonant runs of 4 or more, plus forbidden trigram hits), the saturating record
// total, and on record close a verdict against csr threshold and ban action. Other
// bytes yield nothing. The result sits in an output register; the input stays ready
// while that register is empty or being drained, so a stalled result only blocks new
// input when both are waiting at once. The trigram ROM is read one byte ahead with the
// newest pair, so a trigram check costs one bit-select on the arriving byte.
// Write csr_ registers only while the block is idle.
`include "random_string_scorer_macros.svh"

module random_string_scorer (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] char_byte
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,     // record_end
   // rsp_tdata: [9:0] string_score, [21:10] record_score, [24:22] verdict
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,     // record_done
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   localparam int unsigned RW = rss_pkg::RUN_W;

   // configuration
   logic [rss_pkg::THRESH_W-1:0] thresh_ff;
   logic [rss_pkg::ACTION_W-1:0] action_ff;

   // per-string state
   logic [7:0]    prev_one_ff, prev_one_in;
   logic [1:0]    seen_ff, seen_in;
   logic [rss_pkg::LETTERS-1:0] mask_ff, mask_in;
   logic [RW-1:0] drun_ff, drun_in, dbest_ff, dbest_in;
   logic [RW-1:0] crun_ff, crun_in, cbest_ff, cbest_in;
   logic [RW-1:0] vrun_ff, vrun_in, vbest_ff, vbest_in;
   logic [rss_pkg::HITS_W-1:0]  hits_ff, hits_in;
   logic [rss_pkg::TOTAL_W-1:0] total_ff, total_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [rss_pkg::SCORE_W-1:0]   score_ff, score_in;
   logic [rss_pkg::TOTAL_W-1:0]   rtotal_ff, rtotal_in;
   logic        done_ff, done_in;
   logic [rss_pkg::VERDICT_W-1:0] verdict_ff, verdict_in;

   logic          take, term;
   logic [7:0]    c, c_off;
   logic          is_d, is_c, is_v, tri_hit;
   logic [RW-1:0] d_long, c_long, v_long;
   logic [rss_pkg::SCORE_W:0]   sum;
   logic [rss_pkg::SCORE_W-1:0] score;
   logic [rss_pkg::TOTAL_W:0]   tsum;
   logic [rss_pkg::TOTAL_W-1:0] tsat;

   // Ready whenever the result register is free or empties this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign c          = req_tdata;
   assign term       = (c == 8'd0);
   assign c_off      = c - 8'h61;

   assign is_d = rss_pkg::is_digit(c);
   assign is_c = rss_pkg::is_consonant(c);
   assign is_v = rss_pkg::is_vowel(c);
   // mask_ff is nonzero only for a lowercase pair; the arriving byte must be lowercase.
   assign tri_hit = (seen_ff == 2'd2) && rss_pkg::is_lower(c) && mask_ff[c_off[4:0]];

   // Longest runs at the terminator, including the run still open.
   assign d_long = (drun_ff > dbest_ff) ? drun_ff : dbest_ff;
   assign c_long = (crun_ff > cbest_ff) ? crun_ff : cbest_ff;
   assign v_long = (vrun_ff > vbest_ff) ? vrun_ff : vbest_ff;

   always_comb begin
      sum = {1'b0, hits_ff}
          + ((d_long >= rss_pkg::DIGIT_MIN)  ? (rss_pkg::SCORE_W+1)'(d_long) : '0)
          + ((v_long >= rss_pkg::LETTER_MIN) ? (rss_pkg::SCORE_W+1)'(v_long) : '0)
          + ((c_long >= rss_pkg::LETTER_MIN) ? (rss_pkg::SCORE_W+1)'(c_long) : '0);
      score = sum[rss_pkg::SCORE_W] ? rss_pkg::SCORE_MAX : sum[rss_pkg::SCORE_W-1:0];
      tsum  = {1'b0, total_ff} + (rss_pkg::TOTAL_W+1)'(score);
      tsat  = tsum[rss_pkg::TOTAL_W] ? rss_pkg::TOTAL_MAX : tsum[rss_pkg::TOTAL_W-1:0];
   end

   // Next state of the string trackers.
   always_comb begin
      prev_one_in = prev_one_ff;
      seen_in     = seen_ff;
      mask_in     = mask_ff;
      drun_in = drun_ff;  dbest_in = dbest_ff;
      crun_in = crun_ff;  cbest_in = cbest_ff;
      vrun_in = vrun_ff;  vbest_in = vbest_ff;
      hits_in  = hits_ff;
      total_in = total_ff;
      if (take) begin
         if (term) begin
            // clear the string; drop the record total on close
            prev_one_in = '0;
            seen_in     = '0;
            mask_in     = '0;
            drun_in = '0;  dbest_in = '0;
            crun_in = '0;  cbest_in = '0;
            vrun_in = '0;  vbest_in = '0;
            hits_in  = '0;
            total_in = req_tlast ? '0 : tsat;
         end else begin
            if (is_d) begin
               if (drun_ff < rss_pkg::MAX_RUN) drun_in = drun_ff + 1'b1;
            end else begin
               dbest_in = d_long;
               drun_in  = '0;
            end
            if (is_c) begin
               if (crun_ff < rss_pkg::MAX_RUN) crun_in = crun_ff + 1'b1;
            end else begin
               cbest_in = c_long;
               crun_in  = '0;
            end
            if (is_v) begin
               if (vrun_ff < rss_pkg::MAX_RUN) vrun_in = vrun_ff + 1'b1;
            end else begin
               vbest_in = v_long;
               vrun_in  = '0;
            end
            if (tri_hit && (hits_ff < rss_pkg::HITS_MAX)) hits_in = hits_ff + 1'b1;
            // look up the set for the pair ending in this byte
            mask_in     = rss_pkg::trigram_set(prev_one_ff, c);
            prev_one_in = c;
            if (seen_ff != 2'd2) seen_in = seen_ff + 1'b1;
         end
      end
   end

   // Result register: load on a terminator, hold while stalled, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      score_in     = score_ff;
      rtotal_in    = rtotal_ff;
      done_in      = done_ff;
      verdict_in   = verdict_ff;
      if (take && term) begin
         rsp_valid_in = 1'b1;
         score_in     = score;
         rtotal_in    = tsat;
         done_in      = req_tlast;
         verdict_in   = rss_pkg::VERDICT_PASS;
         if (req_tlast && (tsat > rss_pkg::TOTAL_W'(thresh_ff)))
            verdict_in = rss_pkg::VERDICT_W'(action_ff) + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= rss_pkg::THRESH_RESET;
         action_ff    <= rss_pkg::ACTION_RESET;
         prev_one_ff  <= '0;
         seen_ff      <= '0;
         mask_ff      <= '0;
         drun_ff <= '0;  dbest_ff <= '0;
         crun_ff <= '0;  cbest_ff <= '0;
         vrun_ff <= '0;  vbest_ff <= '0;
         hits_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (rss_pkg::csr_index_type'(csr_index))
               rss_pkg::CSR_THRESHOLD:  thresh_ff <= csr_wdata;
               rss_pkg::CSR_BAN_ACTION: action_ff <= csr_wdata[rss_pkg::ACTION_W-1:0];
               default: ;
            endcase
         end
         prev_one_ff  <= prev_one_in;
         seen_ff      <= seen_in;
         mask_ff      <= mask_in;
         drun_ff <= drun_in;  dbest_ff <= dbest_in;
         crun_ff <= crun_in;  cbest_ff <= cbest_in;
         vrun_ff <= vrun_in;  vbest_ff <= vbest_in;
         hits_ff      <= hits_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff   <= score_in;
      rtotal_ff  <= rtotal_in;
      done_ff    <= done_in;
      verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tdata  = {7'd0, verdict_ff, rtotal_ff, score_ff};

   `RSS_ASSERT_NEXT(a_term_gives_rsp, take && term, rsp_tvalid, "terminator lost its result")
   `RSS_ASSERT_IMP(a_open_pass, rsp_tvalid && !rsp_tlast, verdict_ff == rss_pkg::VERDICT_PASS,
      "verdict set on an open record")
   `RSS_ASSERT_IMP(a_total_covers, rsp_tvalid,
      rtotal_ff >= rss_pkg::TOTAL_W'(score_ff), "record total below string score")

endmodule

/* sim/testbench.sv */
// Testbench for random_string_scorer: drives byte strings and records, predicts
// string and record scores with its own trigram table, and checks every result.
// Depends on rss_pkg and the random_string_scorer RTL.
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [rss_pkg::SCORE_W-1:0]   string_score;
      logic [rss_pkg::TOTAL_W-1:0]   record_score;
      logic                          record_done;
      logic [rss_pkg::VERDICT_W-1:0] verdict;
   } score_type;

   localparam int IDLE_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   random_string_scorer dut (.*);

   always #5 clock = ~clock;

   // Predictor state: a private copy of the per-string and per-record counters.
   logic [7:0]         p_one, p_two;
   logic [1:0]         p_seen;
   logic [7:0]         dig_run, dig_best, con_run, con_best, vow_run, vow_best;
   logic [rss_pkg::HITS_W-1:0]   tri_hits;
   logic [rss_pkg::TOTAL_W-1:0]  rec_total;
   logic [rss_pkg::THRESH_W-1:0] thresh;
   logic [rss_pkg::ACTION_W-1:0] action;
   logic [25:0]        forbid [0:675];

   score_type expected_scores [$];
   int     errors = 0;
   int     idle_cycles = 0;
   bit     burst_on = 1'b1;
   int     burst_left = 0;

   // Build the forbidden-trigram table from the pair/third-letter list.
   task automatic load_trigrams();
      string rows [$];
      string e;
      int    a, b;
      rows = '{"ajfqtvxz","aqdeghjkmnprtxyz","avbfhjqwxz","azjwx","bdbghjkmpqvxz",
"bfbcfgjknpqvwxyz","bgbdfghjkmnqstvxz","bhbfhjkmnqvwxz","bjbcdfghjklmpqtvwxyz",
"bkdfjkmqrvwxyz","blbgpqwxz","bmbcdflmnqz","bnbghjlmnpqtvwx","bpbfgjknqvxz",
"bqbcdefghijklmnopqrstvwxyz","btdgjkpqtxz","bvbfghjklnpqsuvwxz","bwbdfjknpqsuwxyz",
"bxabcdfghijklmnopqtuvwxyz","bzbcdfgjklmnpqrstvwxz","cbbfghjkpqyz","ccgjqxz",
"cdhjkqvwxz","cfgjknqvwyz","cgbdfgjkpqvz","clfghjmpqxz","cmbjkqv","cnbghjkpqwxz",
"cpgjkvxyz","cqabcdefghijklmnopqsvwxyz","crgjqx","csgjxz","cvbdfghjklmnquvwxyz",
"cxabdefghjklmnpqrstuvwxyz","cyjqy","czbcdfghjlpqrtvwxz","dbbdgjnpqtxz","dcgjqxz",
"ddgqz","dfbghjknpqvxyz","dgbfgjqvxz","dhbfkmnqwxz","djbdfghjklnpqrwxz",
"dkcdhjkpqrtuvwxz","dlbfhjknqwxz","dmbfjnqw","dnfgjkmnpqvwz","dpbgjkqvxz",
"dqabcefghijkmnopqtvwxyz","drbfkqtvx","dtqtxz","dvbfghjknqruvwyz","dwcdfjkmnpqsvwxz",
"dxabcdeghjklmnopqrsuvwxyz","dyjyz","dzbcdfgjlnpqrstvxz","ebjqx","egcjvxz","ehhxz",
"ejfghjpqtwxyz","ekjqxz","epjvx","eqbcghijkmotvxyz","evbfpq","fcbdjkmnqvxz",
"fdbgjklqsvyz","fgfgjkmpqtvwxyz","fhbcfghjkpqvwxz","fjbcdfghijklmnpqrstvwxyz",
"fkbcdfghjkmpqrstvwxz","flfjkpqxz","fmdfhjlmvwxyz","fnbdfghjklnqrstvwxz",
"fpbfjknqtvwxz","fqabcefghijklmnopqrstvwxyz","frnqxz","fsgjxz","ftjqx",
"fvbcdfhjklmnpqtuvwxyz","fwbcfgjklmpqstuvwxyz","fxbcdfghjklmnpqrstvwxyz",
"fyghjpquvxy","fzabcdfghjklmnpqrtuvwxyz","gbbcdknpqvwx","gcgjknpqwxz",
"gdcdfghjklmqtvwxz","gfbfghjkmnpqsvwxyz","ggjkqvxz","gjbcdfghjklmnpqrstvwxyz",
"gkbcdfgjkmpqtvwxyz","glfgjklnpqwxz","gmdfjkmnqvxz","gnjkqvxz","gpbjknpqtwxyz",
"gqabcdefghjklmnopqrsvwxyz","grjkqt","gtfjknqvx","guqwx","gvbcdfghjklmpqstvwxyz",
"gwbcdfgjknpqtvwxz","gxabcdefghjklmnopqrstvwxyz","gyjkqxy","gzbcdfgjklmnopqrstvxyz",
"hbbcdfghjkqstvwxz","hccjknqvwxz","hdfgjnpvz","hfbfghjkmnpqtvwxyz","hgbcdfgjknpqsxyz",
"hhbcgklmpqrtvwxz","hjbcdfgjkmpqtvwxyz","hkbcdgkmpqrstvwxz","hljxz","hmdhjqrvwxz",
"hnjrxz","hpbjkmqvwxyz","hqabcdefghijklmnopqrstvwyz","hrcjqx","hsjqxz",
"hvbcdfgjklmnpqstuvwxz","hwbcfgjklnpqsvwxz","hxabcdefghijklmnopqrstuvwxyz",
"hzbcdfghjklmnpqrstuvwxz","ibjqx","ifjqvwz","ihbgjqx","iibjqxy","ijcfgqxy",
"ikbcfqx","iqcdefgjkmnopqtvxyz","iuhiwxy","ivcfgmqx","iwdgjkmnpqtvxz","ixjkqrxz",
"iybcdfghjklpqtvwx","jbbcdghjklmnopqrtuvwxyz","jccfgjkmnopqvwxy","jdcdfghjlmnpqrtvwx",
"jfabcdfghjlnopqrtuvwxyz","jgbcdfghijklmnopqstuvwxyz","jhbcdfghjklmnpqrxyz",
"jjbcdfghjklmnopqrstuvwxyz","jkbcdfghjknqrtwxyz","jlbcfghjmnpqrstuvwxyz",
"jmbcdfghiklmnqrtuvwyz","jnbcfjlmnpqsuvwxz","jpbcdfhijkmpqstvwxyz",
"jqabcdefghijklmnopqrstuvwxyz","jrbdfhjklpqrstuvwxyz","jsbfgjmoqvxyz",
"jtbcdfghjlnpqrtvwxz","jvabcdfghijklpqrstvwxyz","jwbcdefghijklmpqrstuwxyz",
"jxabcdefghijklmnopqrstuvwxyz","jybcdefghjkpqtuvwxyz","jzbcdfghijklmnopqrstuvwxyz",
"kbbcdfghjkmqvwxz","kccdfgjknpqtwxz","kdbfghjklmnpqsvwxyz","kfbdfghjkmnpqsvwxyz",
"kgcghjkmnqtvwxyz","khcfghjkqx","kjbcdfghjkmnpqrstwxyz","kkbcdfgjmpqswxz",
"klcfghlmqstwxz","kmbdfghjknqrstwxyz","knbcdfhjklmnqsvwxz","kpbdfgjkmpqvxyz",
"kqabdefghijklmnopqrstvwxyz","krbcdfghjmqrvwx","ksjqx","ktcdfjklqvx","kuqux",
"kvbcfghjklnpqrstvxyz","kwbcdfgjklmnpqsvwxz","kxabcdefghjklmnopqrstuvwxyz","kyvxy",
"kzbcdefghjklmnpqrstuvwxyz","lbcdgkqtvxz","lcbqx","lgcdfgpqvxz","lhcfghkmnpqrtvx",
"lkqxz","lncfjqxz","lpjkqxz","lqbcdefhijklmopqrstvwxyz","lrdfgjklmpqrtvwx",
"lvbcfhjklmpwxz","lwbcdfgjknqxz","lxbcdfghjklmnpqrtuwz","lzcdjptvxz","mbqxz",
"mdhjkpvz","mffkpqvwxz","mgcfgjnpqsvwxz","mhbchjkmnqvx","mjbcdfghjknpqrstvwxyz",
"mkbcfgklmnpqrvwxz","mljkqz","mmqvz","mnfhjkqxz","mqbdefhjklmnopqtwxyz","mrjklqvwz",
"mtjkq","mvbcfghjklmnqtvwxz","mwbcdfgjklnpqsuvwxyz","mxabcefghijklmnopqrstvwxyz",
"mzbcdfghjkmnpqrstvwxz","nbhkmnqxz","nfbghqvxz","nhfhjkmqtvxz","nkqxz","nlbghjknqvwxz",
"nmdfghjkqtvwxz","npbdjmqwxz","nqabcdfghjklmnopqrtvwxyz","nrbfjkqstvx",
"nvbcdfgjkmnqswxz","nwdgjpqvxz","nxabfghjknopuyz","nzcfqrxz","ocfjvw","ogqxz",
"ohfqxz","ojbfhjmqrswxyz","okqxz","oqbcdefghijklmnopqrstvwxyz","ovbfhjqwx","oyqxy",
"ozfjpqtvx","pbfghjknpqvwz","pcgjq","pdbgjkvwxz","pfhjkmqtvwyz","pgbdfghjkmqsvwxyz",
"phkqvx","pkbcdfhjklmpqrvx","plghkqvwx","pmbfhjlmnqvwyz","pnfjklmnqrtvwz","ppgqwxz",
"pqabcdefghijklmnopqstvwxyz","prhjkqrwx","ptjqxz","pvbdfghjklquvwxyz",
"pwfjkmnpqsuvwxz","pxabcdefghijklmnopqrstuvwxyz","pzbdefghjklmnpqrstuvwxyz",
"qaceghkopqxy","qbbcdfghjklmnqrstuvwxyz","qcabcdfghijklmnopqrstuvwxyz",
"qddefghijklmpqrstuvwxyz","qeabceghjkmopquwxyz","qfabdfghijklmnopqrstuvwxyz",
"qgabcdefghijklmnopqrtuvwxz","qhabcdefghijklmnopqrstuvwxyz","qiefgijkmpwx",
"qjabcdefghijklmnopqrstuvwxyz","qkabcdfghijklmnopqrsuvwxyz","qlabcefghjklmnopqrtuvwxyz",
"qmbdehijklmnoqrtuvxyz","qnbcdefghijklmnoqrtuvwxyz","qoabcdefgijkloqstuvwxyz",
"qpabcdefghijkmnopqrsuvwxyz","qqbcdefghijklmnopstwxyz","qrbdefghijklmnoqruvwxyz",
"qsbcdefgijknqruvwxz","qtbefghjklmnpqtuvwxz","qucfgjkpwz","qvabdefghjklmnopqrtuvwxyz",
"qwbcdfghijkmnopqrstuvwxyz","qxabcdefghijklmnopqrstuvwxyz","qyabcdefghjklmnopqrstuvwxyz",
"qzabcdefghijklmnopqrstuvwxyz","rbfxz","rgjvxz","rhhjkqrxz","rjbdfghjklmpqrstvwxz",
"rkqxz","rljnq","rpjxz","rqbcdefghijklmnopqrtvwxy","rrjpqxz","rvbcdfghjmpqrvwxz",
"rwbfgjklqsvxz","rxbcdfgjkmnopqrtuvwxz","rzdjpqvxz","sbkpqtvxz","sdjqxz","sfbghjkpqw",
"sgcgjkqvwxz","sjbfghjkmnpqrstvwxz","skqxz","slgjkqwxz","smfkqwxz","sndhjknqvwxz",
"sqbfghjkmopstvwxz","srjklqrwxz","svbfhjklmnqtwxyz","swjkpqvwxz",
"sxbcdefghjklmnopqrtuvwxyz","syqxy","szbdfgjpqsvxz","tbcghjkmnpqtvwx","tcjnqvx",
"tdbfgjkpqtvxz","tfghjkqvwyz","tgbdfghjkmpqsx","tjbdfhjklmnpqstvwxyz",
"tkbcdfghjklmpqvwxz","tljkqwxz","tmbknqtwxz","tnfhjkmqvwxz","tpbjpqvwxz",
"tqabdefhijklmnopqrstvwxyz","trgjqvx","tvbcfghjknpquvwxz","twbcdfjknqvz",
"txbcdefghjklmnopqrsuvwxz","tzjqxz","ucfjmvx","ufjpqvx","ugqvx","uhbcgjkpvxz",
"ujwbfghklmqvwx","ukfgqxz","uqbcdfghijklmnopqrtwxyz","uufijkqvwyz","uvbcdfghjkmpqtwxz",
"uwdgjnquvxyz","uxjqxz","uyjqxyz","uzfgkpqrx","vbbcdfhijklmpqrtuvxyz",
"vcbgjklnpqtvwxyz","vdbdghjklnqvwxyz","vfbfghijklmnpqtuvxz","vgbcdgjkmnpqtuvwxyz",
"vhbcghijklmnpqrtuvwxyz","vjabcdfghijklmnpqrstuvwxyz","vkbcdefgjklmnpqruvwxyz",
"vlhjkmpqrvwxz","vmbfghjknpquvxyz","vnbdhjkmnpqrtuvwxz","vpbcdeghjkmopqtuvwyz",
"vqabcdefghijklmnopqrstvwxyz","vrfghjknqrtvwxz","vsdfgjmqz","vtbdfgjklmnqtx",
"vuafhjquwxy","vvcdfghjkmnpqrtuwxz","vwabcdefghijklmnopqrtuvwxyz",
"vxabcefghjklmnopqrstuvxyz","vyoqx","vzabcdefgjklmpqrstvwxyz","wbbdfghjpqtvxz",
"wcbdfgjkmnqvwx","wddfjpqvxz","wfcdghjkmqvwxyz","wgbcdfgjknpqtvwxyz","whcdghjklpqvwxz",
"wjbfghijklmnpqrstvwxyz","wkcdfgjkpqtuvxz","wljqvxz","wmdghjlnqtvwxz","wpdfgjkpqtvwxz",
"wqabcdefghijklmnopqrstuvwxyz","wrcfghjlmpqwx","wtbdgjlmnpqtvx","wuaikoquvwy",
"wvbcdfghjklmnpqrtuvwxyz","wwbcdgkpqstuvxyz","wxabcdefghijklmnopqrstuvwxz","wyjquwxy",
"wzbcdfghjkmnopqrstuvwxz","xaajoqy","xbbcdfghjkmnpqsvwxz","xcbcdgjkmnqsvwxz",
"xdbcdfghjklnpqstuvwxyz","xfbcdfghjkmnpqtvwxyz","xgbcdfghjkmnpqstvwxyz",
"xhcdfghjkmnpqrstvwxz","xijkqy","xjabcdefghijklmnopqrstvwxyz","xkabcdfghjkmnopqrstuvwxyz",
"xlbcdfghjklmnpqrvwxz","xmbcdfghjknpqvwxz","xnbcdfghjklmnpqrvwxyz","xpbcfjknpqvxz",
"xqabcdefghijklmnopqrstvwxyz","xrbcdfghjklnpqrsvwyz","xsbdfgjmnqrsvxz","xtjkpqvwxz",
"xufhjkquwx","xvbcdefghjklmnpqrsuvwxyz","xwbcdfghjklmnpqrtuvwxyz","xxbcdefghjkmnpqrstuwyz",
"xyjxy","xzabcdefghjklmnpqrstuvwxyz","ybcfghjmpqtvwxz","ycbdfgjmpqsvwx","ydchjkpqvwx",
"yfbcdghjmnpqsvwx","ygcfjkpqtxz","yhbcdfghjkpqx","yihjqwxy","yjbcdfghjklmnpqrstvwxyz",
"ykbcdfgpqvwxz","ymdfgjqvxz","ypbcdfgjkmqxz","yqabcdefghijklmnopqrstuvwxyz","yrjqx",
"ytbcfgjnpqx","yvbcdfghjlmnpqstvwxz","ywbfgjklmnpqstuvwxz","yxbcdfghjknpqrstuvwxz",
"yybcdfghjklpqrstvwxz","yzbcdfjklmnpqtvwx","zbdfgjklmnpqstvwxz","zcbcdfgjmnpqstvwxy",
"zdbcdfghjklmnpqstvwxy","zfbcdfghijkmnopqrstvwxyz","zgbcdfgjkmnpqtvwxyz",
"zhbcfghjlpqstvwxz","zjabcdfghjklmnpqrstuvwxyz","zkbcdfghjklmpqstvwxz",
"zlbcdfghjlnpqrstvwxz","zmbdfghjklmpqstvwxyz","znbcdfghjlmnpqrstuvwxz",
"zpbcdfhjklmnpqstvwxz","zqabcdefghijklmnopqrstuvwxyz","zrbcfghjklmnpqrstvwxyz",
"zsbdfgjmnqrsuwxyz","ztbcdfgjkmnpqtuvwxz","zuajqx","zvbcdfghjklmnpqrstuvwxyz",
"zwbcdfghjklmnpqrstuvwxyz","zxabcdefghijklmnopqrstuvwxyz","zyfxy","zzcdfhjnpqrvx"};
      for (int i = 0; i < 676; i++) forbid[i] = '0;
      foreach (rows[r]) begin
         e = rows[r];
         a = e[0] - 8'h61;
         b = e[1] - 8'h61;
         for (int k = 2; k < e.len(); k++)
            forbid[a * 26 + b][e[k] - 8'h61] = 1'b1;
      end
   endtask

   function automatic bit lower_letter(logic [7:0] c);
      return c >= 8'h61 && c <= 8'h7a;
   endfunction

   function automatic bit vowel_letter(logic [7:0] c);
      return c == 8'h61 || c == 8'h65 || c == 8'h69 || c == 8'h6f || c == 8'h75;
   endfunction

   // Extend a run on a hit; on a miss fold it into the best and restart.
   task automatic bump_run(bit hit, inout logic [7:0] run, inout logic [7:0] best);
      if (hit) begin
         if (run < rss_pkg::MAX_RUN) run++;
      end else begin
         if (run > best) best = run;
         run = '0;
      end
   endtask

   task automatic clear_string_state();
      p_one = '0; p_two = '0; p_seen = '0;
      dig_run = '0; dig_best = '0; con_run = '0; con_best = '0;
      vow_run = '0; vow_best = '0; tri_hits = '0;
   endtask

   // Advance the predictor by one accepted byte; queue a score on a terminator.
   task automatic score_byte(logic [7:0] c, logic close);
      int        d, v, k, s, t;
      score_type r;
      if (c != 8'h00) begin
         bump_run(c >= 8'h30 && c <= 8'h39, dig_run, dig_best);
         bump_run(lower_letter(c) && !vowel_letter(c) && c != 8'h79, con_run, con_best);
         bump_run(vowel_letter(c), vow_run, vow_best);
         if (p_seen == 2'd2 && lower_letter(p_two) && lower_letter(p_one) &&
             lower_letter(c))
            if (forbid[(p_two - 8'h61) * 26 + (p_one - 8'h61)][c - 8'h61] &&
                tri_hits < rss_pkg::HITS_MAX)
               tri_hits++;
         p_two = p_one;
         p_one = c;
         if (p_seen < 2'd2) p_seen++;
      end else begin
         d = dig_run > dig_best ? dig_run : dig_best;
         v = vow_run > vow_best ? vow_run : vow_best;
         k = con_run > con_best ? con_run : con_best;
         s = tri_hits;
         if (d >= rss_pkg::DIGIT_MIN) s += d;
         if (v >= rss_pkg::LETTER_MIN) s += v;
         if (k >= rss_pkg::LETTER_MIN) s += k;
         if (s > rss_pkg::SCORE_MAX) s = rss_pkg::SCORE_MAX;
         t = rec_total + s;
         if (t > rss_pkg::TOTAL_MAX) t = rss_pkg::TOTAL_MAX;
         rec_total = rss_pkg::TOTAL_W'(t);
         r.string_score = rss_pkg::SCORE_W'(s);
         r.record_score = rss_pkg::TOTAL_W'(t);
         r.record_done = close;
         if (close && t > thresh)
            r.verdict = rss_pkg::VERDICT_W'(rss_pkg::VERDICT_KILL + action);
         else
            r.verdict = rss_pkg::VERDICT_W'(rss_pkg::VERDICT_PASS);
         expected_scores.insert(expected_scores.size(), r);
         clear_string_state();
         if (close) rec_total = '0;
      end
   endtask

   // Send one item; the sender sometimes idles between bursts of random length.
   task automatic send_byte(logic [7:0] c, logic close = 1'b0);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= close;
      do @(posedge clock); while (!req_tready);
      score_byte(c, close);
   endtask

   task automatic send_text(string s, logic close = 1'b0);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(8'h00, close);
   endtask

   // Hold until every queued score has arrived, then let the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_scores.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(rss_pkg::csr_index_type idx, logic [6:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == rss_pkg::CSR_THRESHOLD) thresh = value;
      else action = value[1:0];
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_text("aaaaa");                       // vowel run
      send_text("bcdfgh", 1'b1);                // consonant run, closes record
      send_text("0123456789");                  // digit run
      send_text("", 1'b1);                      // empty string still reports
      send_text("qxzjqx");                      // forbidden trigrams
      send_byte(8'hff, 1'b1);                   // tlast on a data byte is ignored
      send_byte(8'h80);
      send_text("ABCyyQ", 1'b1);                // uppercase and y break runs
      send_text("xyzzy0a9");
      send_text("", 1'b1);
   endtask

   // Push one digit run past its limit and close the record.
   task automatic test_saturation();
      for (int i = 0; i < 260; i++) send_byte(8'(8'h30 + (i % 10)));
      send_byte(8'h00, 1'b1);
      drain();
   endtask

   function automatic logic [7:0] random_char();
      string vowels = "aeiou";
      string rare   = "qxzjvkw";
      string common = "bcdfghklmnpqrstvwxz";
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'(8'h61 + $urandom_range(0, 25));
         3:       return vowels[$urandom_range(0, 4)];
         4:       return rare[$urandom_range(0, 6)];
         5, 6:    return 8'(8'h30 + $urandom_range(0, 9));
         7:       return 8'(8'h41 + $urandom_range(0, 25));
         8:       return 8'($urandom_range(1, 255));
         default: return common[$urandom_range(0, 18)];
      endcase
   endfunction

   task automatic test_random(int n_items);
      int sent;
      sent = 0;
      while (sent < n_items) begin
         repeat ($urandom_range(0, 12)) begin
            send_byte(random_char(), $urandom_range(0, 1));
            sent++;
         end
         send_byte(8'h00, $urandom_range(0, 3) == 0);
         sent++;
      end
      send_byte(8'h00, 1'b1);
      drain();
   endtask

   // Receiver: stall at random, with ready sometimes forced high.
   always @(posedge clock) begin
      logic [15:0] pattern;
      pattern = 16'($urandom);
      rsp_tready <= reset ? 1'b0 : ($urandom_range(0, 3) == 0 ? 1'b1 : pattern[0] | pattern[3]);
   end

   // Check each accepted score against the oldest prediction.
   always @(posedge clock) begin
      score_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_scores.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            errors++;
         end else begin
            exp_r = expected_scores.pop_front();
            if (rsp_tdata[9:0] !== exp_r.string_score) begin
               $error("string_score expected %0d actual %0d", exp_r.string_score,
                      rsp_tdata[9:0]);
               errors++;
            end
            if (rsp_tdata[21:10] !== exp_r.record_score) begin
               $error("record_score expected %0d actual %0d", exp_r.record_score,
                      rsp_tdata[21:10]);
               errors++;
            end
            if (rsp_tlast !== exp_r.record_done) begin
               $error("record_done expected %0d actual %0d", exp_r.record_done, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[24:22] !== exp_r.verdict) begin
               $error("verdict expected %0d actual %0d", exp_r.verdict, rsp_tdata[24:22]);
               errors++;
            end
         end
      end
   end

   // Watchdog: end the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset ||
          (!req_tvalid && expected_scores.size() == 0))
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("random_string_scorer: mismatch");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      load_trigrams();
      clear_string_state();
      rec_total = '0;
      thresh = rss_pkg::THRESH_RESET;
      action = rss_pkg::ACTION_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      write_csr(rss_pkg::CSR_THRESHOLD, 7'd1);
      write_csr(rss_pkg::CSR_BAN_ACTION, 7'd0);
      test_saturation();
      write_csr(rss_pkg::CSR_THRESHOLD, 7'd100);
      write_csr(rss_pkg::CSR_BAN_ACTION, 7'd1);
      test_random(130);
      write_csr(rss_pkg::CSR_THRESHOLD, 7'd5);
      write_csr(rss_pkg::CSR_BAN_ACTION, 7'd2);
      test_random(130);
      write_csr(rss_pkg::CSR_THRESHOLD, 7'd20);
      write_csr(rss_pkg::CSR_BAN_ACTION, 7'd3);
      test_random(130);
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_scores.size() == 0)
         $display("random_string_scorer: match");
      else
         $display("random_string_scorer: mismatch");
      $finish;
   end

endmodule

/* random_string_scorer.f */
+incdir+hdl
hdl/rss_pkg.sv
hdl/random_string_scorer.sv
sim/testbench.sv
